>>> hdl/lfuc_pkg.sv
// Shared types and constants of the LFU byte-budget object cache.
// Holds the entry record, command and status codes, and the control/status
// structs between the controller and the datapath. Depends on nothing.
package lfuc_pkg;

  // Table depth; the slot and count widths below are sized for it.
  localparam int ENTRIES = 64;

  localparam int ID_W    = 31;
  localparam int SIZE_W  = 32;
  localparam int LOCKS_W = 16;
  localparam int USES_W  = 32;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [LOCKS_W-1:0] LOCKS_MAX = '1;
  localparam logic [USES_W-1:0]  USES_MAX  = '1;

  // Division by five of a small count: (x * 52429) >> 18.
  localparam int DIV5_MUL   = 52429;
  localparam int DIV5_MUL_W = 16;
  localparam int DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_PURGE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_LOCKED     = 3'd3,
    ST_NO_ROOM    = 3'd4,
    ST_FULL       = 3'd5,
    ST_NOT_LOCKED = 3'd6
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_IDX_ZERO,
    OP_IDX_LIVE,
    OP_READ_IDX,
    OP_READ_IDX_M1,
    OP_LK_STEP,
    OP_LK_MISS_END,
    OP_HIT_WRITE,
    OP_REL_WRITE,
    OP_EV_START,
    OP_EV_STEP,
    OP_EV_PICK,
    OP_EV_MARK,
    OP_REMOVE_MARK,
    OP_SW_START,
    OP_SW_STEP,
    OP_SW_END,
    OP_SHIFT_STEP,
    OP_INSERT,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
    logic [LOCKS_W-1:0] locks;
    logic [USES_W-1:0]  uses;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    dp_op_e  op;
    logic    res_load;
    status_e res_status;
    logic    res_slot;
    logic    res_lock;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_at_live;
    logic idx_at_pos;
    logic lk_less;
    logic hit;
    cmd_e cmd;
    logic locks_zero;
    logic table_full;
    logic too_big;
    logic fits;
    logic best_valid;
    logic alone_fit;
    logic acc_cover;
  } dp_stat_t;

endpackage

>>> hdl/lfu_byte_budget_object_cache.sv
// Top level of the LFU byte-budget object cache: APB register, controller
// and datapath. Depends on lfuc_pkg, lfuc_ctrl and lfuc_dp.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  cmd_i, object_id_i, object_size_i
//   out      output     out_valid_o/out_ready_i status_o, slot_index_o, lock_count_o,
//                                              bytes_used_o, entry_count_o
//   cfg      APB        psel/penable/pready    paddr, pwdata, prdata (capacity_bytes)
//
// Each entry touched by a scan takes a read state and a use state, since the
// entry memory has a registered read port. A lookup scans up to the first id
// not below the one sought, a sweep or a victim pass scans every live entry,
// and an insert shifts each entry above its slot. An eviction repeats the
// victim pass once per victim chosen. Reset is asynchronous and active low,
// and it clears the counters and control state; the entry memory needs no
// clearing pass because only slots below the entry count are ever read.
// One item is worked at a time; the next item is taken while a result
// still waits in the output register.
module lfu_byte_budget_object_cache
  import lfuc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [ID_W-1:0]     object_id_i,
  input  logic [SIZE_W-1:0]   object_size_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [LOCKS_W-1:0]  lock_count_o,
  output logic [SIZE_W-1:0]   bytes_used_o,
  output logic [COUNT_W-1:0]  entry_count_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // The byte budget resets to one mebibyte.
  localparam logic [SIZE_W-1:0] CAP_RESET = 32'h0010_0000;

  logic [SIZE_W-1:0] cap_q;
  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;

  // The only register sits at byte address zero; address bit 2 selects
  // the empty space beyond it, so writes there are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cap_q <= pwdata;
    end
  end

  assign prdata = paddr[2] ? '0 : cap_q;
  assign pready = 1'b1;

  lfuc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd),
    .dp_stat_i   (dp_stat)
  );

  lfuc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .dp_stat_o     (dp_stat),
    .cap_i         (cap_q),
    .cmd_i         (cmd_i),
    .object_id_i   (object_id_i),
    .object_size_i (object_size_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .lock_count_o  (lock_count_o),
    .bytes_used_o  (bytes_used_o),
    .entry_count_o (entry_count_o)
  );

endmodule

>>> hdl/lfuc_dp.sv
// Datapath of the LFU object cache: entry memory, scan counters, byte and
// entry bookkeeping, victim search registers and result registers.
// Depends on lfuc_pkg; driven by lfuc_ctrl through dp_cmd_t.
module lfuc_dp
  import lfuc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             dp_cmd_i,
  output dp_stat_t            dp_stat_o,
  input  logic [SIZE_W-1:0]   cap_i,
  input  logic [1:0]          cmd_i,
  input  logic [ID_W-1:0]     object_id_i,
  input  logic [SIZE_W-1:0]   object_size_i,
  output logic [2:0]          status_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic [LOCKS_W-1:0]  lock_count_o,
  output logic [SIZE_W-1:0]   bytes_used_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = SIZE_W + CW;
  localparam int PW = CW + 1 + DIV5_MUL_W;
  localparam int NW = SIZE_W + 1;

  entry_t mem [ENTRIES];
  entry_t rd_q;

  cmd_e               cmd_q;
  logic [ID_W-1:0]    id_q;
  logic [SIZE_W-1:0]  size_q;

  logic [CW-1:0]      idx_q, wr_q, pos_q, live_q;
  logic               hit_q;
  logic [SIZE_W-1:0]  occ_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [ENTRIES-1:0] sel_q, flag_q;
  logic               best_valid_q, alone_q;

  logic [IW-1:0]      best_q;
  logic [USES_W-1:0]  best_uses_q;
  logic [STAMP_W-1:0] best_stamp_q;
  logic [SIZE_W-1:0]  best_size_q;
  logic [AW-1:0]      acc_q;
  logic [NW-1:0]      need_q;

  status_e            res_status_q, status_q;
  logic [SLOT_W-1:0]  res_slot_q, slot_q;
  logic [LOCKS_W-1:0] res_locks_q, locks_q;
  logic [SIZE_W-1:0]  bytes_q;
  logic [COUNT_W-1:0] count_q;

  dp_op_e             op;
  logic               re, we;
  logic [IW-1:0]      raddr, waddr;
  entry_t             wdata;
  logic [CW-1:0]      idx_m1;
  logic               evict, cand, better;
  logic [SIZE_W-1:0]  free_bytes;
  logic [CW:0]        live_p2;
  logic [PW-1:0]      prod;
  logic [NW-1:0]      need_d;
  logic [AW-1:0]      acc_sum;
  logic [LOCKS_W-1:0] hit_locks, lock_d;
  logic [ENTRIES-1:0] best_hot, pos_hot;

  assign op     = dp_cmd_i.op;
  assign idx_m1 = idx_q - CW'(1);
  assign re     = (op == OP_READ_IDX) || (op == OP_READ_IDX_M1);
  assign raddr  = (op == OP_READ_IDX_M1) ? idx_m1[IW-1:0] : idx_q[IW-1:0];

  assign evict = (rd_q.locks == '0) &&
                 ((cmd_q == CMD_PURGE) || flag_q[idx_q[IW-1:0]]);
  assign better = (rd_q.uses < best_uses_q) ||
                  ((rd_q.uses == best_uses_q) && (rd_q.stamp < best_stamp_q));
  assign cand = (rd_q.locks == '0) && !sel_q[idx_q[IW-1:0]] &&
                (!best_valid_q || better);

  assign free_bytes = (occ_q >= cap_i) ? '0 : (cap_i - occ_q);
  assign live_p2    = {1'b0, live_q} + (CW+1)'(2);
  assign prod       = PW'(live_p2) * PW'(DIV5_MUL);
  assign need_d     = {1'b0, size_q} + NW'(prod >> DIV5_SHIFT);
  assign acc_sum    = acc_q + AW'(best_size_q);
  assign hit_locks  = (rd_q.locks == LOCKS_MAX) ? rd_q.locks : rd_q.locks + 16'd1;
  assign best_hot   = {{(ENTRIES-1){1'b0}}, 1'b1} << best_q;
  assign pos_hot    = {{(ENTRIES-1){1'b0}}, 1'b1} << pos_q[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = pos_q[IW-1:0];
    wdata = rd_q;
    case (op)
      OP_HIT_WRITE: begin
        we          = 1'b1;
        wdata.uses  = (rd_q.uses == USES_MAX) ? rd_q.uses : rd_q.uses + 32'd1;
        wdata.locks = hit_locks;
        wdata.stamp = stamp_q + 32'd1;
      end
      OP_REL_WRITE: begin
        we          = 1'b1;
        wdata.locks = rd_q.locks - 16'd1;
      end
      OP_SW_STEP: begin
        we    = !evict && (wr_q != idx_q);
        waddr = wr_q[IW-1:0];
      end
      OP_SHIFT_STEP: begin
        we    = 1'b1;
        waddr = idx_q[IW-1:0];
      end
      OP_INSERT: begin
        we    = 1'b1;
        wdata = '{id: id_q, size: size_q, locks: 16'd1, uses: '0,
                  stamp: stamp_q + 32'd1};
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    case (op)
      OP_HIT_WRITE: lock_d = hit_locks;
      OP_REL_WRITE: lock_d = rd_q.locks - 16'd1;
      OP_INSERT:    lock_d = 16'd1;
      default:      lock_d = dp_cmd_i.res_lock ? rd_q.locks : '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      wr_q         <= '0;
      pos_q        <= '0;
      hit_q        <= 1'b0;
      live_q       <= '0;
      occ_q        <= '0;
      stamp_q      <= '0;
      sel_q        <= '0;
      flag_q       <= '0;
      best_valid_q <= 1'b0;
      alone_q      <= 1'b0;
    end else begin
      case (op)
        OP_CAPTURE, OP_IDX_ZERO: idx_q <= '0;
        OP_IDX_LIVE: idx_q <= live_q;
        OP_LK_STEP: begin
          if (rd_q.id < id_q) begin
            idx_q <= idx_q + CW'(1);
          end else begin
            pos_q <= idx_q;
            hit_q <= (rd_q.id == id_q);
          end
        end
        OP_LK_MISS_END: begin
          pos_q <= idx_q;
          hit_q <= 1'b0;
        end
        OP_HIT_WRITE: stamp_q <= stamp_q + 32'd1;
        OP_EV_START: begin
          idx_q        <= '0;
          sel_q        <= '0;
          best_valid_q <= 1'b0;
          alone_q      <= 1'b0;
        end
        OP_EV_STEP: begin
          if (cand) begin
            best_valid_q <= 1'b1;
          end
          idx_q <= idx_q + CW'(1);
        end
        OP_EV_PICK: begin
          idx_q        <= '0;
          best_valid_q <= 1'b0;
          if (best_valid_q) begin
            sel_q <= sel_q | best_hot;
            if (need_q <= {1'b0, best_size_q}) begin
              alone_q <= 1'b1;
            end
          end
        end
        OP_EV_MARK: begin
          if (alone_q) begin
            flag_q <= best_hot;
          end else if (acc_q != '0) begin
            flag_q <= sel_q;
          end else begin
            flag_q <= '0;
          end
          idx_q <= '0;
          wr_q  <= '0;
        end
        OP_REMOVE_MARK: begin
          flag_q <= pos_hot;
          idx_q  <= '0;
          wr_q   <= '0;
        end
        OP_SW_START: begin
          idx_q <= '0;
          wr_q  <= '0;
        end
        OP_SW_STEP: begin
          idx_q <= idx_q + CW'(1);
          if (evict) begin
            occ_q <= occ_q - rd_q.size;
          end else begin
            wr_q <= wr_q + CW'(1);
          end
        end
        OP_SW_END: live_q <= wr_q;
        OP_SHIFT_STEP: idx_q <= idx_m1;
        OP_INSERT: begin
          stamp_q <= stamp_q + 32'd1;
          live_q  <= live_q + CW'(1);
          occ_q   <= occ_q + size_q;
        end
        default: idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_CAPTURE) begin
      cmd_q  <= cmd_e'(cmd_i);
      id_q   <= object_id_i;
      size_q <= object_size_i;
    end
    if (op == OP_EV_START) begin
      acc_q  <= '0;
      need_q <= need_d;
    end
    if ((op == OP_EV_STEP) && cand) begin
      best_q       <= idx_q[IW-1:0];
      best_uses_q  <= rd_q.uses;
      best_stamp_q <= rd_q.stamp;
      best_size_q  <= rd_q.size;
    end
    if ((op == OP_EV_PICK) && best_valid_q && (need_q > {1'b0, best_size_q})) begin
      acc_q <= acc_sum;
    end
    if (dp_cmd_i.res_load) begin
      res_status_q <= dp_cmd_i.res_status;
      res_slot_q   <= dp_cmd_i.res_slot ? SLOT_W'(pos_q) : '0;
      res_locks_q  <= lock_d;
    end
    if (op == OP_FINISH) begin
      status_q <= res_status_q;
      slot_q   <= res_slot_q;
      locks_q  <= res_locks_q;
      bytes_q  <= occ_q;
      count_q  <= COUNT_W'(live_q);
    end
  end

  assign dp_stat_o.idx_at_live = (idx_q == live_q);
  assign dp_stat_o.idx_at_pos  = (idx_q == pos_q);
  assign dp_stat_o.lk_less     = (rd_q.id < id_q);
  assign dp_stat_o.hit         = hit_q;
  assign dp_stat_o.cmd         = cmd_q;
  assign dp_stat_o.locks_zero  = (rd_q.locks == '0);
  assign dp_stat_o.table_full  = (live_q >= CW'(ENTRIES));
  assign dp_stat_o.too_big     = (size_q > cap_i);
  assign dp_stat_o.fits        = (free_bytes >= size_q);
  assign dp_stat_o.best_valid  = best_valid_q;
  assign dp_stat_o.alone_fit   = (need_q <= {1'b0, best_size_q});
  assign dp_stat_o.acc_cover   = (acc_sum >= AW'(need_q));

  assign status_o      = status_q;
  assign slot_index_o  = slot_q;
  assign lock_count_o  = locks_q;
  assign bytes_used_o  = bytes_q;
  assign entry_count_o = count_q;

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(ENTRIES))
    else $error("entry count beyond table depth");

  a_sweep_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_SW_STEP) |-> (wr_q <= idx_q))
    else $error("compaction write index ahead of read index");

  a_shift_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_SHIFT_STEP) |-> (idx_q > pos_q))
    else $error("insert shift reached below the insertion slot");

  a_insert_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_INSERT) |=> (occ_q == $past(occ_q) + $past(size_q)))
    else $error("insert did not add the object size");

endmodule

>>> hdl/lfuc_ctrl.sv
// Controller of the LFU object cache: one state machine that sequences
// lookup, victim search, compaction, insert shift and result hand-off.
// Depends on lfuc_pkg; drives lfuc_dp through dp_cmd_t.
module lfuc_ctrl
  import lfuc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dp_cmd_t  dp_cmd_o,
  input  dp_stat_t dp_stat_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_CHK,
    S_LK_USE,
    S_DISPATCH,
    S_EV_CHK,
    S_EV_USE,
    S_EV_PICK,
    S_EV_MARK,
    S_SW_CHK,
    S_SW_USE,
    S_EV_POST,
    S_IN_CHK,
    S_IN_USE,
    S_IN_WR,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   relook_q, relook_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    relook_d    = relook_q;
    out_valid_d = out_valid_q;
    dp_cmd_o    = '{op: OP_NONE, res_load: 1'b0, res_status: ST_HIT,
                    res_slot: 1'b0, res_lock: 1'b0};
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.op = OP_CAPTURE;
          relook_d    = 1'b0;
          state_d     = S_LK_CHK;
        end
      end
      S_LK_CHK: begin
        if (dp_stat_i.idx_at_live) begin
          dp_cmd_o.op = OP_LK_MISS_END;
          state_d     = S_DISPATCH;
        end else begin
          dp_cmd_o.op = OP_READ_IDX;
          state_d     = S_LK_USE;
        end
      end
      S_LK_USE: begin
        dp_cmd_o.op = OP_LK_STEP;
        state_d     = dp_stat_i.lk_less ? S_LK_CHK : S_DISPATCH;
      end
      S_DISPATCH: begin
        dp_cmd_o.res_load = 1'b1;
        state_d           = S_FIN;
        case (dp_stat_i.cmd)
          CMD_ACQUIRE: begin
            if (relook_q) begin
              dp_cmd_o.op       = OP_IDX_LIVE;
              dp_cmd_o.res_load = 1'b0;
              state_d           = S_IN_CHK;
            end else if (dp_stat_i.hit) begin
              dp_cmd_o.op         = OP_HIT_WRITE;
              dp_cmd_o.res_status = ST_HIT;
              dp_cmd_o.res_slot   = 1'b1;
            end else if (dp_stat_i.table_full) begin
              dp_cmd_o.res_status = ST_FULL;
            end else if (dp_stat_i.too_big) begin
              dp_cmd_o.res_status = ST_NO_ROOM;
            end else if (dp_stat_i.fits) begin
              dp_cmd_o.op       = OP_IDX_LIVE;
              dp_cmd_o.res_load = 1'b0;
              state_d           = S_IN_CHK;
            end else begin
              dp_cmd_o.op       = OP_EV_START;
              dp_cmd_o.res_load = 1'b0;
              state_d           = S_EV_CHK;
            end
          end
          CMD_RELEASE: begin
            if (!dp_stat_i.hit) begin
              dp_cmd_o.res_status = ST_NOT_FOUND;
            end else if (dp_stat_i.locks_zero) begin
              dp_cmd_o.res_status = ST_NOT_LOCKED;
              dp_cmd_o.res_slot   = 1'b1;
            end else begin
              dp_cmd_o.op         = OP_REL_WRITE;
              dp_cmd_o.res_status = ST_HIT;
              dp_cmd_o.res_slot   = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (!dp_stat_i.hit) begin
              dp_cmd_o.res_status = ST_NOT_FOUND;
            end else if (!dp_stat_i.locks_zero) begin
              dp_cmd_o.res_status = ST_LOCKED;
              dp_cmd_o.res_slot   = 1'b1;
              dp_cmd_o.res_lock   = 1'b1;
            end else begin
              dp_cmd_o.op         = OP_REMOVE_MARK;
              dp_cmd_o.res_status = ST_HIT;
              dp_cmd_o.res_slot   = 1'b1;
              state_d             = S_SW_CHK;
            end
          end
          default: begin
            dp_cmd_o.op         = OP_SW_START;
            dp_cmd_o.res_status = ST_HIT;
            state_d             = S_SW_CHK;
          end
        endcase
      end
      S_EV_CHK: begin
        if (dp_stat_i.idx_at_live) begin
          state_d = S_EV_PICK;
        end else begin
          dp_cmd_o.op = OP_READ_IDX;
          state_d     = S_EV_USE;
        end
      end
      S_EV_USE: begin
        dp_cmd_o.op = OP_EV_STEP;
        state_d     = S_EV_CHK;
      end
      S_EV_PICK: begin
        dp_cmd_o.op = OP_EV_PICK;
        if (!dp_stat_i.best_valid || dp_stat_i.alone_fit || dp_stat_i.acc_cover) begin
          state_d = S_EV_MARK;
        end else begin
          state_d = S_EV_CHK;
        end
      end
      S_EV_MARK: begin
        dp_cmd_o.op = OP_EV_MARK;
        state_d     = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (dp_stat_i.idx_at_live) begin
          dp_cmd_o.op = OP_SW_END;
          state_d     = (dp_stat_i.cmd == CMD_ACQUIRE) ? S_EV_POST : S_FIN;
        end else begin
          dp_cmd_o.op = OP_READ_IDX;
          state_d     = S_SW_USE;
        end
      end
      S_SW_USE: begin
        dp_cmd_o.op = OP_SW_STEP;
        state_d     = S_SW_CHK;
      end
      S_EV_POST: begin
        if (dp_stat_i.fits) begin
          dp_cmd_o.op = OP_IDX_ZERO;
          relook_d    = 1'b1;
          state_d     = S_LK_CHK;
        end else begin
          dp_cmd_o.res_load   = 1'b1;
          dp_cmd_o.res_status = ST_NO_ROOM;
          state_d             = S_FIN;
        end
      end
      S_IN_CHK: begin
        if (dp_stat_i.idx_at_pos) begin
          state_d = S_IN_WR;
        end else begin
          dp_cmd_o.op = OP_READ_IDX_M1;
          state_d     = S_IN_USE;
        end
      end
      S_IN_USE: begin
        dp_cmd_o.op = OP_SHIFT_STEP;
        state_d     = S_IN_CHK;
      end
      S_IN_WR: begin
        dp_cmd_o.op         = OP_INSERT;
        dp_cmd_o.res_load   = 1'b1;
        dp_cmd_o.res_status = ST_INSERTED;
        dp_cmd_o.res_slot   = 1'b1;
        state_d             = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.op = OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      relook_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      relook_q    <= relook_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
